>>> design/mtns_pkg.sv
// ----------------------------------------------------------------------------
// mtns_pkg
// Types, constants and helpers shared by the MIDI track to note stream block.
// ----------------------------------------------------------------------------
package mtns_pkg;

  localparam int unsigned TpqW      = 15;
  localparam int unsigned TempoW    = 24;
  localparam int unsigned DeltaW    = 32;
  localparam int unsigned ProdW     = DeltaW + TempoW;
  localparam int unsigned DivW      = 25;
  localparam int unsigned CmdQDepth = 2;

  localparam logic [TpqW-1:0]   TpqReset   = 15'd96;
  localparam logic [TempoW-1:0] TempoReset = 24'd500000;
  localparam logic [9:0]        UsPerMs    = 10'd1000;

  localparam logic [7:0] StMeta   = 8'hFF;
  localparam logic [7:0] StSysex  = 8'hF0;
  localparam logic [7:0] StEscape = 8'hF7;
  localparam logic [3:0] HiNoteOn = 4'h9;
  localparam logic [3:0] HiNoteOff = 4'h8;
  localparam logic [3:0] HiPolyAt  = 4'hA;
  localparam logic [3:0] HiCtrl    = 4'hB;
  localparam logic [3:0] HiBend    = 4'hE;

  localparam logic [7:0] MetaTrackName = 8'h03;
  localparam logic [7:0] MetaInstrName = 8'h04;
  localparam logic [7:0] MetaTempo     = 8'h51;
  localparam logic [7:0] MetaTimeSig   = 8'h58;
  localparam logic [7:0] MetaKeySig    = 8'h59;
  localparam logic [7:0] MetaEot       = 8'h2F;
  localparam logic [7:0] EotByte       = 8'hFF;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_META_LEN = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_ERR   = 2'd1,
    CMD_DELAY = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [7:0]        data;
    logic [DeltaW-1:0] delta;
    logic [TempoW-1:0] tempo;
  } cmd_t;

  function automatic logic [7:0] note_code(input logic [7:0] pitch);
    logic [7:0] code;
    code = 8'd0;
    case (pitch)
      8'd60: code = 8'd1;
      8'd62: code = 8'd2;
      8'd64: code = 8'd3;
      8'd65: code = 8'd4;
      8'd67: code = 8'd5;
      8'd69: code = 8'd6;
      8'd71: code = 8'd7;
      8'd72: code = 8'd8;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

>>> design/mtns_if.sv
// ----------------------------------------------------------------------------
// mtns channel interfaces
// Valid/ready channels for track bytes in and stream records out.
// ----------------------------------------------------------------------------
interface mtns_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  modport source (output valid, output track_byte, input ready);
  modport sink   (input valid, input track_byte, output ready);
endinterface

interface mtns_rec_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       last;
  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

>>> design/midi_track_to_note_stream_core.sv
// ----------------------------------------------------------------------------
// midi_track_to_note_stream_core
// MIDI track chunk parser producing note, delay and end records.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  track_i   in   track_byte[7:0]                      valid/ready
//  note_o    out  kind, out_byte[7:0], error_code, last valid/ready
//  cfg       in   cfg_wdata_i[14:0] ticks per quarter  cfg_we_i
//
//  A byte is taken whenever the two-entry command queue has room. A delay
//  record goes through the generator as a shift-add multiply, a restoring
//  divide and 3 record transactions; other commands give one record.
//  Reset clears all parser state; tempo returns to 500000 us. A stalled
//  output holds its record and fills the queue.
// ----------------------------------------------------------------------------
module midi_track_to_note_stream_core #(
  parameter int unsigned CmdDepth = mtns_pkg::CmdQDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mtns_pkg::TpqW-1:0] cfg_wdata_i,
  mtns_byte_if.sink                 track_i,
  mtns_rec_if.source                note_o
);
  import mtns_pkg::*;

  logic [TpqW-1:0] tpq_q;
  logic            full, empty, push, pop;
  cmd_t            cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tpq_q <= TpqReset;
    else if (cfg_we_i) tpq_q <= cfg_wdata_i;
  end

  assign track_i.ready = !full;

  mtns_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (track_i.valid && !full),
    .byte_i   (track_i.track_byte),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  mtns_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  mtns_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tpq_i   (tpq_q),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .rec_o   (note_o)
  );

endmodule

>>> design/mtns_front.sv
// ----------------------------------------------------------------------------
// mtns_front
// Event parser: decodes delta times, running status and meta events, and
// pushes one command per byte that needs a result.
// ----------------------------------------------------------------------------
module mtns_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output mtns_pkg::cmd_t    cmd_o
);
  import mtns_pkg::*;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_FIRST     = 9'b000000100,
    PH_META_LEN  = 9'b000001000,
    PH_META_DATA = 9'b000010000,
    PH_NOTE_VEL  = 9'b000100000,
    PH_SKIP_ONE  = 9'b001000000,
    PH_SYX_LEN   = 9'b010000000,
    PH_SYX_SKIP  = 9'b100000000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        rs_q, rs_d, fd_q, fd_d;
  logic [7:0]        mtype_q, mtype_d, mlen_q, mlen_d, mcnt_q, mcnt_d;
  logic [31:0]       mpay_q, mpay_d;
  logic [DeltaW-1:0] acc_q, acc_d;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic [31:0]       tsig_q, tsig_d;
  logic [15:0]       ksig_q, ksig_d;
  logic              done_q, done_d;

  logic              do_dispatch, do_finish;
  logic [7:0]        disp_fd, code;
  logic [DeltaW-1:0] acc_sh;

  always_comb begin
    phase_d = phase_q; rs_d = rs_q; fd_d = fd_q;
    mtype_d = mtype_q; mlen_d = mlen_q; mcnt_d = mcnt_q; mpay_d = mpay_q;
    acc_d = acc_q; tempo_d = tempo_q; tsig_d = tsig_q; ksig_d = ksig_q;
    done_d = done_q;
    push_o = 1'b0;
    cmd_o = '0;
    cmd_o.tempo = tempo_q;
    do_dispatch = 1'b0;
    do_finish = 1'b0;
    disp_fd = byte_i;
    acc_sh = {acc_q[DeltaW-8:0], byte_i[6:0]};
    code = note_code(fd_q);
    if (accept_i && !done_q) begin
      unique case (phase_q)
        PH_DELTA: begin
          if (!byte_i[7]) begin
            if (acc_sh != '0) begin
              push_o = 1'b1;
              cmd_o.op = CMD_DELAY;
              cmd_o.delta = acc_sh;
            end
            acc_d = '0;
            phase_d = PH_STATUS;
          end else begin
            acc_d = acc_sh;
          end
        end
        PH_STATUS: begin
          if (byte_i[7]) begin
            rs_d = byte_i;
            phase_d = PH_FIRST;
          end else begin
            fd_d = byte_i;
            do_dispatch = 1'b1;
          end
        end
        PH_FIRST: begin
          fd_d = byte_i;
          do_dispatch = 1'b1;
        end
        PH_META_LEN: begin
          mlen_d = byte_i;
          mcnt_d = '0;
          mpay_d = '0;
          if (byte_i == 8'd0) do_finish = 1'b1;
          else phase_d = PH_META_DATA;
        end
        PH_META_DATA: begin
          mpay_d = {mpay_q[23:0], byte_i};
          mcnt_d = mcnt_q + 8'd1;
          if (mcnt_d >= mlen_q) do_finish = 1'b1;
        end
        PH_NOTE_VEL: begin
          phase_d = PH_DELTA;
          if (code == 8'd0) begin
            push_o = 1'b1;
            cmd_o.op = CMD_ERR;
            cmd_o.data = {6'd0, ERR_UNKNOWN};
          end else if (byte_i != 8'd0) begin
            push_o = 1'b1;
            cmd_o.op = CMD_BYTE;
            cmd_o.data = code;
          end
        end
        PH_SKIP_ONE: begin
          phase_d = PH_DELTA;
          push_o = 1'b1;
          cmd_o.op = CMD_ERR;
          cmd_o.data = {6'd0, ERR_UNKNOWN};
        end
        PH_SYX_LEN: begin
          acc_d = acc_sh;
          if (byte_i[7]) phase_d = PH_SYX_LEN;
          else if (acc_sh == '0) begin
            phase_d = PH_DELTA;
            push_o = 1'b1;
            cmd_o.op = CMD_ERR;
            cmd_o.data = {6'd0, ERR_UNKNOWN};
          end else phase_d = PH_SYX_SKIP;
        end
        PH_SYX_SKIP: begin
          acc_d = acc_q - 1'b1;
          if (acc_d == '0) begin
            phase_d = PH_DELTA;
            push_o = 1'b1;
            cmd_o.op = CMD_ERR;
            cmd_o.data = {6'd0, ERR_UNKNOWN};
          end
        end
        default: phase_d = PH_DELTA;
      endcase

      if (do_dispatch) begin
        if (rs_d == StMeta) begin
          mtype_d = disp_fd;
          phase_d = PH_META_LEN;
        end else if (rs_d == StSysex || rs_d == StEscape) begin
          // count restarts from this byte alone
          acc_d = {{(DeltaW-7){1'b0}}, disp_fd[6:0]};
          if (disp_fd[7]) phase_d = PH_SYX_LEN;
          else if (disp_fd[6:0] == 7'd0) begin
            phase_d = PH_DELTA;
            push_o = 1'b1;
            cmd_o.op = CMD_ERR;
            cmd_o.data = {6'd0, ERR_UNKNOWN};
          end else phase_d = PH_SYX_SKIP;
        end else if (rs_d[7:4] == HiNoteOn) begin
          phase_d = PH_NOTE_VEL;
        end else if (rs_d[7:4] == HiNoteOff || rs_d[7:4] == HiPolyAt ||
                     rs_d[7:4] == HiCtrl || rs_d[7:4] == HiBend) begin
          phase_d = PH_SKIP_ONE;
        end else begin
          phase_d = PH_DELTA;
          push_o = 1'b1;
          cmd_o.op = CMD_ERR;
          cmd_o.data = {6'd0, ERR_UNKNOWN};
        end
      end

      if (do_finish) begin
        phase_d = PH_DELTA;
        unique case (mtype_q)
          MetaTrackName, MetaInstrName: ;
          MetaTempo: begin
            if (mlen_d != 8'd3) begin
              push_o = 1'b1; cmd_o.op = CMD_ERR; cmd_o.data = {6'd0, ERR_META_LEN};
            end else tempo_d = mpay_d[TempoW-1:0];
          end
          MetaTimeSig: begin
            if (mlen_d != 8'd4) begin
              push_o = 1'b1; cmd_o.op = CMD_ERR; cmd_o.data = {6'd0, ERR_META_LEN};
            end else tsig_d = mpay_d;
          end
          MetaKeySig: begin
            if (mlen_d != 8'd2) begin
              push_o = 1'b1; cmd_o.op = CMD_ERR; cmd_o.data = {6'd0, ERR_META_LEN};
            end else ksig_d = mpay_d[15:0];
          end
          MetaEot: begin
            push_o = 1'b1;
            if (mlen_d != 8'd0) begin
              cmd_o.op = CMD_ERR; cmd_o.data = {6'd0, ERR_META_LEN};
            end else begin
              cmd_o.op = CMD_BYTE; cmd_o.data = EotByte;
              done_d = 1'b1;
            end
          end
          default: begin
            push_o = 1'b1; cmd_o.op = CMD_ERR; cmd_o.data = {6'd0, ERR_UNKNOWN};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      rs_q    <= '0;
      fd_q    <= '0;
      mtype_q <= '0;
      mlen_q  <= '0;
      mcnt_q  <= '0;
      mpay_q  <= '0;
      acc_q   <= '0;
      tempo_q <= TempoReset;
      tsig_q  <= '0;
      ksig_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      fd_q    <= fd_d;
      mtype_q <= mtype_d;
      mlen_q  <= mlen_d;
      mcnt_q  <= mcnt_d;
      mpay_q  <= mpay_d;
      acc_q   <= acc_d;
      tempo_q <= tempo_d;
      tsig_q  <= tsig_d;
      ksig_q  <= ksig_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> design/mtns_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mtns_cmd_fifo
// Short command queue between the parser and the record generator.
// ----------------------------------------------------------------------------
module mtns_cmd_fifo #(
  parameter int unsigned Depth = mtns_pkg::CmdQDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtns_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output mtns_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);
  import mtns_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> design/mtns_back.sv
// ----------------------------------------------------------------------------
// mtns_back
// Record generator: shift-add multiply, restoring divide, record output.
// ----------------------------------------------------------------------------
module mtns_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mtns_pkg::TpqW-1:0] tpq_i,
  input  logic                      empty_i,
  input  mtns_pkg::cmd_t            cmd_i,
  output logic                      pop_o,
  mtns_rec_if.source                rec_o
);
  import mtns_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_e;

  bstate_e           st_q;
  cmd_op_e           op_q;
  logic [7:0]        data_q;
  logic [DeltaW-1:0] delta_q;
  logic [TempoW-1:0] tempo_q;
  logic [ProdW-1:0]  prod_q;
  logic [DivW-1:0]   div_q;
  logic [DivW:0]     rem_q, trial;
  logic [5:0]        cnt_q;
  logic [1:0]        idx_q;
  logic              ovalid_q, okind_q, olast_q;
  logic [7:0]        obyte_q;
  logic [1:0]        oerr_q;
  logic              load;
  logic [15:0]       qsat;
  logic [TpqW-1:0]   tpq_nz;

  assign tpq_nz = (tpq_i == '0) ? TpqW'(1) : tpq_i;
  assign trial  = {rem_q[DivW-1:0], prod_q[ProdW-1]};
  assign qsat   = (|prod_q[ProdW-1:16]) ? 16'hFFFF : prod_q[15:0];
  assign load   = (st_q == B_EMIT) && (!ovalid_q || rec_o.ready);
  assign pop_o  = (st_q == B_IDLE) && !empty_i;

  assign rec_o.valid      = ovalid_q;
  assign rec_o.kind       = okind_q;
  assign rec_o.out_byte   = obyte_q;
  assign rec_o.error_code = oerr_q;
  assign rec_o.last       = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      unique case (st_q)
        B_IDLE: begin
          if (!empty_i) begin
            cnt_q <= '0;
            if (cmd_i.op == CMD_DELAY) begin
              st_q <= B_MUL;
            end else begin
              st_q  <= B_EMIT;
              idx_q <= 2'd2;
            end
          end
        end
        B_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(TempoW - 1)) begin
            st_q  <= B_DIV;
            cnt_q <= '0;
          end
        end
        B_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(ProdW - 1)) begin
            st_q  <= B_EMIT;
            idx_q <= '0;
          end
        end
        B_EMIT: begin
          if (load) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 2'd2) st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
      if (load) ovalid_q <= 1'b1;
      else if (rec_o.ready) ovalid_q <= 1'b0;
    end
  end

  // datapath: product, then quotient shifted into the same register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q    <= cmd_i.op;
      data_q  <= cmd_i.data;
      delta_q <= cmd_i.delta;
      tempo_q <= cmd_i.tempo;
      prod_q  <= '0;
      rem_q   <= '0;
      div_q   <= DivW'(tpq_nz * UsPerMs);
    end else if (st_q == B_MUL) begin
      prod_q  <= {prod_q[ProdW-2:0], 1'b0} +
                 (tempo_q[TempoW-1] ? ProdW'(delta_q) : '0);
      tempo_q <= {tempo_q[TempoW-2:0], 1'b0};
    end else if (st_q == B_DIV) begin
      if (trial >= {1'b0, div_q}) begin
        rem_q  <= trial - {1'b0, div_q};
        prod_q <= {prod_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q  <= trial;
        prod_q <= {prod_q[ProdW-2:0], 1'b0};
      end
    end
    if (load) begin
      olast_q <= (idx_q == 2'd2);
      okind_q <= (op_q == CMD_ERR);
      oerr_q  <= (op_q == CMD_ERR) ? data_q[1:0] : ERR_NONE;
      case (idx_q)
        2'd0:    obyte_q <= 8'd0;
        2'd1:    obyte_q <= qsat[15:8];
        default: obyte_q <= (op_q == CMD_DELAY) ? qsat[7:0] :
                            (op_q == CMD_ERR) ? 8'd0 : data_q;
      endcase
    end
  end

endmodule

>>> design/mtns_checker.sv
// ----------------------------------------------------------------------------
// mtns_checker
// Port-level checks on the record output of the note stream core.
// ----------------------------------------------------------------------------
module mtns_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic       kind_i,
  input logic [7:0] byte_i,
  input logic [1:0] err_i,
  input logic       last_i
);

  // a stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(byte_i) && $stable(kind_i) && $stable(last_i))
    else $error("record changed while stalled");

  // records of one delay follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_i |=> valid_i)
    else $error("gap inside a multi-record transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i |-> byte_i == 8'd0 && err_i != 2'd0 && last_i)
    else $error("malformed error report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !kind_i |-> err_i == 2'd0)
    else $error("stream byte with error code");

endmodule

bind midi_track_to_note_stream_core mtns_checker u_mtns_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (note_o.valid),
  .ready_i (note_o.ready),
  .kind_i  (note_o.kind),
  .byte_i  (note_o.out_byte),
  .err_i   (note_o.error_code),
  .last_i  (note_o.last)
);

>>> dv/tb_midi_track_to_note_stream_core_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel helpers
// The block's own channel interfaces are reused; this file carries only a
// small type shared by the stimulus and checking logic of the testbench.
// ----------------------------------------------------------------------------
package tb_mtns_types_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;
  } note_rec_t;

endpackage

>>> dv/tb_midi_track_to_note_stream_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_track_to_note_stream_core
// Feeds track-chunk bytes with random gaps and output stalls, predicts every
// note, delay, end and error record in a local parser model and compares each
// record transaction field by field. Ticks per quarter is changed between
// phases while the block is idle; reset is applied once at the start.
// ----------------------------------------------------------------------------
module tb_midi_track_to_note_stream_core;
  import mtns_pkg::*;
  import tb_mtns_types_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  typedef enum logic [3:0] {
    P_DELTA, P_STATUS, P_FIRST, P_META_LEN, P_META_DATA, P_NOTE_VEL,
    P_SKIP_ONE, P_SYX_LEN, P_SYX_SKIP
  } phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TpqW-1:0] cfg_wdata_i = '0;

  mtns_byte_if track_if ();
  mtns_rec_if  note_if ();

  midi_track_to_note_stream_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .track_i     (track_if.sink),
    .note_o      (note_if.source)
  );

  always #5 clk_i = ~clk_i;

  // parser model state
  phase_e      m_phase;
  logic [7:0]  m_status, m_first, m_mtype, m_mlen, m_mcount;
  logic [31:0] m_acc, m_payload;
  logic [23:0] m_tempo;
  logic        m_done;
  logic [TpqW-1:0] m_tpq;

  note_rec_t   expected_recs[$];
  logic [7:0]  pending_bytes[$];
  note_rec_t   step_recs[$];
  int unsigned mismatches = 0;
  int unsigned recs_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          hold_sender = 1'b0;

  function automatic logic [7:0] pitch_code(logic [7:0] p);
    case (p)
      8'd60: return 8'd1;
      8'd62: return 8'd2;
      8'd64: return 8'd3;
      8'd65: return 8'd4;
      8'd67: return 8'd5;
      8'd69: return 8'd6;
      8'd71: return 8'd7;
      8'd72: return 8'd8;
      default: return 8'd0;
    endcase
  endfunction

  task automatic push_rec(logic kind, logic [7:0] b, err_e code);
    note_rec_t r;
    r.kind = kind;
    r.out_byte = b;
    r.error_code = code;
    r.last = 1'b0;
    step_recs.push_back(r);
  endtask

  task automatic meta_close();
    m_phase = P_DELTA;
    case (m_mtype)
      MetaTrackName, MetaInstrName: ;
      MetaTempo: if (m_mlen != 8'd3) push_rec(1'b1, 8'd0, ERR_META_LEN);
                 else m_tempo = m_payload[23:0];
      MetaTimeSig: if (m_mlen != 8'd4) push_rec(1'b1, 8'd0, ERR_META_LEN);
      MetaKeySig: if (m_mlen != 8'd2) push_rec(1'b1, 8'd0, ERR_META_LEN);
      MetaEot: begin
        if (m_mlen != 8'd0) begin
          push_rec(1'b1, 8'd0, ERR_META_LEN);
        end else begin
          push_rec(1'b0, EotByte, ERR_NONE);
          m_done = 1'b1;
        end
      end
      default: push_rec(1'b1, 8'd0, ERR_UNKNOWN);
    endcase
  endtask

  task automatic syx_count(logic [7:0] b);
    m_acc = (m_acc << 7) + b[6:0];
    if (b[7]) m_phase = P_SYX_LEN;
    else if (m_acc == 0) begin
      m_phase = P_DELTA;
      push_rec(1'b1, 8'd0, ERR_UNKNOWN);
    end else m_phase = P_SYX_SKIP;
  endtask

  task automatic route_event();
    if (m_status == StMeta) begin
      m_mtype = m_first;
      m_phase = P_META_LEN;
    end else if (m_status == StSysex || m_status == StEscape) begin
      m_acc = 0;
      syx_count(m_first);
    end else if (m_status[7:4] == HiNoteOn) begin
      m_phase = P_NOTE_VEL;
    end else if (m_status[7:4] inside {HiNoteOff, HiPolyAt, HiCtrl, HiBend}) begin
      m_phase = P_SKIP_ONE;
    end else begin
      m_phase = P_DELTA;
      push_rec(1'b1, 8'd0, ERR_UNKNOWN);
    end
  endtask

  // Work out the records one accepted track byte causes.
  task automatic parse_track_byte(logic [7:0] b);
    logic [63:0] dly;
    logic [7:0]  code;
    step_recs.delete();
    if (!m_done) begin
      case (m_phase)
        P_DELTA: begin
          m_acc = (m_acc << 7) + b[6:0];
          if (!b[7]) begin
            if (m_acc != 0) begin
              dly = (64'(m_acc) * 64'(m_tempo)) /
                    (64'((m_tpq == 0) ? 1 : m_tpq) * 64'd1000);
              if (dly > 64'd65535) dly = 64'd65535;
              push_rec(1'b0, 8'd0, ERR_NONE);
              push_rec(1'b0, dly[15:8], ERR_NONE);
              push_rec(1'b0, dly[7:0], ERR_NONE);
            end
            m_acc = 0;
            m_phase = P_STATUS;
          end
        end
        P_STATUS: begin
          if (b[7]) begin
            m_status = b;
            m_phase = P_FIRST;
          end else begin
            m_first = b;
            route_event();
          end
        end
        P_FIRST: begin
          m_first = b;
          route_event();
        end
        P_META_LEN: begin
          m_mlen = b;
          m_mcount = 0;
          m_payload = 0;
          if (b == 0) meta_close();
          else m_phase = P_META_DATA;
        end
        P_META_DATA: begin
          m_payload = (m_payload << 8) | b;
          m_mcount = m_mcount + 8'd1;
          if (m_mcount >= m_mlen) meta_close();
        end
        P_NOTE_VEL: begin
          code = pitch_code(m_first);
          m_phase = P_DELTA;
          if (code == 0) push_rec(1'b1, 8'd0, ERR_UNKNOWN);
          else if (b != 0) push_rec(1'b0, code, ERR_NONE);
        end
        P_SKIP_ONE: begin
          m_phase = P_DELTA;
          push_rec(1'b1, 8'd0, ERR_UNKNOWN);
        end
        P_SYX_LEN: syx_count(b);
        P_SYX_SKIP: begin
          m_acc = m_acc - 1;
          if (m_acc == 0) begin
            m_phase = P_DELTA;
            push_rec(1'b1, 8'd0, ERR_UNKNOWN);
          end
        end
        default: m_phase = P_DELTA;
      endcase
    end
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
    foreach (step_recs[k]) expected_recs.push_back(step_recs[k]);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_if.valid <= 1'b0;
      track_if.track_byte <= 8'd0;
    end else begin
      if (track_if.valid && track_if.ready) begin
        parse_track_byte(track_if.track_byte);
        bytes_sent++;
        void'(pending_bytes.pop_front());
        src_gap = gap_len();
      end
      if (track_if.valid && !track_if.ready) begin
        // hold the waiting transaction
      end else if (hold_sender || pending_bytes.size() == 0 || src_gap > 0) begin
        if (src_gap > 0) src_gap--;
        track_if.valid <= 1'b0;
      end else begin
        track_if.valid <= 1'b1;
        track_if.track_byte <= pending_bytes[0];
      end
    end
  end

  // monitor
  int unsigned snk_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    note_rec_t want;
    if (!rst_ni) begin
      note_if.ready <= 1'b0;
    end else begin
      cycle_count++;
      if (note_if.valid && note_if.ready) begin
        recs_seen++;
        if (expected_recs.size() == 0) begin
          report_mismatch("unexpected record, out_byte", note_if.out_byte, 0);
        end else begin
          want = expected_recs.pop_front();
          if (note_if.kind !== want.kind) report_mismatch("kind", note_if.kind, want.kind);
          if (note_if.out_byte !== want.out_byte)
            report_mismatch("out_byte", note_if.out_byte, want.out_byte);
          if (note_if.error_code !== want.error_code)
            report_mismatch("error_code", note_if.error_code, want.error_code);
          if (note_if.last !== want.last) report_mismatch("last", note_if.last, want.last);
        end
        snk_gap = gap_len();
      end
      if (snk_gap > 0) begin
        snk_gap--;
        note_if.ready <= 1'b0;
      end else begin
        note_if.ready <= 1'b1;
      end
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_bytes(input logic [7:0] b[]);
    foreach (b[k]) pending_bytes.push_back(b[k]);
  endtask

  task automatic add_delta(int unsigned d);
    if (d >= 32'h200000) pending_bytes.push_back(8'h80 | 8'(d >> 21));
    if (d >= 32'h4000) pending_bytes.push_back(8'h80 | 8'((d >> 14) & 8'h7F));
    if (d >= 32'h80) pending_bytes.push_back(8'h80 | 8'((d >> 7) & 8'h7F));
    pending_bytes.push_back(8'(d & 32'h7F));
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || track_if.valid || expected_recs.size() != 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_tpq(logic [TpqW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    m_tpq = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_event();
    int unsigned r;
    logic [7:0] p[8];
    p = '{60, 62, 64, 65, 67, 69, 71, 72};
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) add_delta($urandom_range(0, 3000));
    else if ($urandom_range(0, 9) == 0) add_delta($urandom);
    else add_delta($urandom_range(0, 2));
    if (r < 45) begin
      if ($urandom_range(0, 2) != 0) pending_bytes.push_back(8'h90 | 8'($urandom_range(0, 15)));
      pending_bytes.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 127))
                              : p[$urandom_range(0, 7)]);
      pending_bytes.push_back($urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom_range(1, 127)));
    end else if (r < 55) begin
      add_bytes('{StMeta, MetaTempo, 8'd3, 8'($urandom), 8'($urandom), 8'($urandom)});
    end else if (r < 62) begin
      add_bytes('{StMeta, MetaTimeSig, 8'd4, 8'($urandom), 8'($urandom), 8'd24, 8'd8});
    end else if (r < 67) begin
      add_bytes('{StMeta, MetaKeySig, 8'($urandom_range(1, 3)), 8'($urandom), 8'd0, 8'd0});
    end else if (r < 72) begin
      add_bytes('{StMeta, 8'($urandom_range(3, 4)), 8'd2, 8'h41, 8'h42});
    end else if (r < 80) begin
      pending_bytes.push_back(8'($urandom_range(8'h80, 8'hEF)));
      pending_bytes.push_back(8'($urandom_range(0, 127)));
      pending_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (r < 86) begin
      add_bytes('{($urandom_range(0, 1) ? StSysex : StEscape), 8'($urandom_range(0, 4)),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
    end else if (r < 90) begin
      add_bytes('{StMeta, 8'($urandom_range(0, 127)), 8'd1, 8'($urandom)});
    end else begin
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic run_random(int unsigned n);
    int unsigned start;
    start = bytes_sent + pending_bytes.size();
    while (bytes_sent + pending_bytes.size() < start + n) random_event();
  endtask

  task automatic finish_track();
    add_bytes('{8'd0, StMeta, MetaEot, 8'd0, 8'd0, 8'h90, 8'd60, 8'd100});
  endtask

  task automatic restart_model();
    m_phase = P_DELTA; m_status = 0; m_first = 0; m_mtype = 0; m_mlen = 0;
    m_mcount = 0; m_acc = 0; m_payload = 0; m_tempo = TempoReset; m_done = 0;
    m_tpq = TpqReset;
  endtask

  initial begin
    restart_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: note, running status, velocity zero, unmapped pitch, long delta
    add_bytes('{8'd0, 8'h90, 8'd60, 8'd127, 8'h81, 8'h00, 8'd72, 8'd1,
                8'd0, 8'd62, 8'd0, 8'd0, 8'd61, 8'd5,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80, 8'd1, 8'd2});
    wait_drained();
    write_tpq(15'd1);
    hold_sender = 1'b1;
    add_bytes('{8'd0, 8'hC3, 8'd5, 8'd0, 8'hF3, 8'd1, 8'd0, 8'hFF, 8'h51, 8'd2,
                8'd1, 8'd2, 8'd0, 8'hFF, 8'h58, 8'd0, 8'd0, 8'hF0, 8'd0,
                8'd0, 8'hF7, 8'h81, 8'h00, 8'h7F, 8'd0, 8'hFF, 8'h51, 8'd3,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    hold_sender = 1'b0;
    wait_drained();
    write_tpq(15'd0);
    add_bytes('{8'd5, 8'h9F, 8'd64, 8'd9});
    wait_drained();
    write_tpq(15'd32767);
    run_random(70);
    wait_drained();
    write_tpq(15'd480);
    run_random(40);
    // pause the sender until every expected record has arrived
    hold_sender = 1'b1;
    while (expected_recs.size() != 0) @(posedge clk_i);
    hold_sender = 1'b0;
    run_random(40);
    finish_track();
    wait_drained();
    write_tpq(15'd96);
    while (bytes_sent < 220) begin
      run_random(20);
      wait_drained();
    end
    wait_drained();
    $display("sent %0d track bytes, checked %0d records", bytes_sent, recs_seen);
    $display("covered notes, delays, meta lengths, SysEx skips, end of track, tpq 0..32767");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
